// ===== hdl/block_intra_predictor_unit_defines.svh =====
// Assertion macros shared by the intra predictor modules.
// The macros expect signals named clk and rst in the module that uses them.
`ifndef BLOCK_INTRA_PREDICTOR_UNIT_DEFINES_SVH
`define BLOCK_INTRA_PREDICTOR_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BIP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BIP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/bip_pkg.sv =====
// Shared types and constants of the block intra predictor.
// No dependencies; used by every module of the block except bip_ram.
package bip_pkg;

  localparam int BLOCK_SIZE = 256;
  localparam int ADDR_W     = $clog2(BLOCK_SIZE);
  localparam int IDX_W      = 8;
  localparam int SAMPLE_W   = 16;
  localparam int VALUE_W    = 17;
  localparam int DATA_W     = 40;
  localparam int CFG_W      = 5;
  localparam int CFG_IDX_W  = 3;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W     = 2;
  localparam int QCNT_W     = QPTR_W + 1;

  localparam logic [IDX_W:0] BLOCK_LIMIT = (IDX_W + 1)'(BLOCK_SIZE);

  typedef enum logic [1:0] {
    OP_LOAD_LEFT = 2'd0,
    OP_LOAD_TOP  = 2'd1,
    OP_PIXEL     = 2'd2
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PRED_MODE   = 3'd0,
    REG_SAMPLE_BITS = 3'd1,
    REG_LEFT_AVAIL  = 3'd2,
    REG_TOP_AVAIL   = 3'd3,
    REG_RECON_MODE  = 3'd4
  } reg_idx_t;

  typedef enum logic [2:0] {
    MODE_GREY = 3'd0,
    MODE_LEFT = 3'd1,
    MODE_TOP  = 3'd2,
    MODE_AVG  = 3'd3,
    MODE_AUTO = 3'd4
  } mode_t;

  typedef struct packed {
    op_t                       kind;
    logic [ADDR_W-1:0]         row;
    logic [ADDR_W-1:0]         col;
    logic signed [VALUE_W-1:0] sample;
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } head_t;

endpackage

// ===== hdl/bip_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module bip_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/bip_front.sv =====
// Front end: accepts input words, drops those without effect, and queues the rest.
// Depends on bip_pkg and the assertion macro header.
`include "block_intra_predictor_unit_defines.svh"

module bip_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [bip_pkg::DATA_W-1:0]    s_tdata,
  input  logic [1:0]                    s_tuser,
  output bip_pkg::head_t                head,
  input  logic                          pop
);

  bip_pkg::entry_t                queue [bip_pkg::QUEUE_DEPTH];
  logic [bip_pkg::QPTR_W-1:0]     wr_ptr;
  logic [bip_pkg::QPTR_W-1:0]     rd_ptr;
  logic [bip_pkg::QCNT_W-1:0]     count;
  logic [bip_pkg::QCNT_W-1:0]     count_next;
  logic [bip_pkg::IDX_W-1:0]      row;
  logic [bip_pkg::IDX_W-1:0]      col;
  logic                           keep;
  logic                           push;
  bip_pkg::entry_t                item;

  assign row = s_tdata[7:0];
  assign col = s_tdata[15:8];

  always_comb begin
    item.kind   = bip_pkg::op_t'(s_tuser);
    item.row    = row[bip_pkg::ADDR_W-1:0];
    item.col    = col[bip_pkg::ADDR_W-1:0];
    item.sample = s_tdata[32:16];
    case (bip_pkg::op_t'(s_tuser))
      bip_pkg::OP_LOAD_LEFT: keep = {1'b0, row} < bip_pkg::BLOCK_LIMIT;
      bip_pkg::OP_LOAD_TOP:  keep = {1'b0, col} < bip_pkg::BLOCK_LIMIT;
      bip_pkg::OP_PIXEL:     keep = ({1'b0, row} < bip_pkg::BLOCK_LIMIT) &&
                                    ({1'b0, col} < bip_pkg::BLOCK_LIMIT);
      default:               keep = 1'b0;
    endcase
  end

  assign s_tready = count != bip_pkg::QCNT_W'(bip_pkg::QUEUE_DEPTH);
  assign push     = s_tvalid && s_tready && keep;

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + bip_pkg::QCNT_W'(1);
    end else if (pop && !push) begin
      count_next = count - bip_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= wr_ptr + bip_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + bip_pkg::QPTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= item;
    end
  end

  assign head.valid = count != '0;
  assign head.entry = queue[rd_ptr];

  `BIP_ASSERT_NOW(a_pop_not_empty, pop, count != '0, "queue popped while empty")
  `BIP_ASSERT_NOW(a_count_bound, 1'b1, count <= bip_pkg::QCNT_W'(bip_pkg::QUEUE_DEPTH),
    "queue count above depth")
  `BIP_ASSERT_NOW(a_full_blocks, count == bip_pkg::QCNT_W'(bip_pkg::QUEUE_DEPTH), !s_tready,
    "input ready while queue full")

endmodule

// ===== hdl/bip_back.sv =====
// Back end: configuration registers, neighbor stores, prediction and clipping pipeline.
// Depends on bip_pkg, bip_ram and the assertion macro header.
`include "block_intra_predictor_unit_defines.svh"

module bip_back (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [bip_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bip_pkg::CFG_W-1:0]         cfg_data,
  input  bip_pkg::head_t                    head,
  output logic                              pop,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [bip_pkg::SAMPLE_W-1:0]      out_pred,
  output logic signed [bip_pkg::VALUE_W-1:0] out_result
);

  logic [2:0]                       pred_mode;
  logic [4:0]                       sample_bits;
  logic                             left_avail;
  logic                             top_avail;
  logic                             recon_mode;

  logic                             advance;
  logic                             we_left;
  logic                             we_top;
  logic [bip_pkg::SAMPLE_W-1:0]     left_q;
  logic [bip_pkg::SAMPLE_W-1:0]     top_q;

  logic                             a_valid;
  logic signed [bip_pkg::VALUE_W-1:0] a_sample;
  logic                             b_valid;
  logic [bip_pkg::SAMPLE_W-1:0]     b_pred;
  logic signed [bip_pkg::VALUE_W-1:0] b_sample;

  logic [4:0]                       bits_eff;
  logic [bip_pkg::SAMPLE_W-1:0]     grey;
  logic [bip_pkg::VALUE_W-1:0]      maxval;
  logic [2:0]                       mode_eff;
  logic [bip_pkg::VALUE_W-1:0]      nb_sum;
  logic [bip_pkg::SAMPLE_W-1:0]     pred_next;
  logic signed [bip_pkg::VALUE_W:0] max_s;
  logic signed [bip_pkg::VALUE_W:0] raw;
  logic signed [bip_pkg::VALUE_W:0] clipped;

  always_ff @(posedge clk) begin
    if (rst) begin
      pred_mode   <= bip_pkg::MODE_GREY;
      sample_bits <= 5'd8;
      left_avail  <= 1'b0;
      top_avail   <= 1'b0;
      recon_mode  <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        bip_pkg::REG_PRED_MODE:   pred_mode   <= cfg_data[2:0];
        bip_pkg::REG_SAMPLE_BITS: sample_bits <= cfg_data[4:0];
        bip_pkg::REG_LEFT_AVAIL:  left_avail  <= cfg_data[0];
        bip_pkg::REG_TOP_AVAIL:   top_avail   <= cfg_data[0];
        bip_pkg::REG_RECON_MODE:  recon_mode  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign advance = !out_valid || out_ready;
  assign pop     = head.valid && advance;
  assign we_left = pop && (head.entry.kind == bip_pkg::OP_LOAD_LEFT);
  assign we_top  = pop && (head.entry.kind == bip_pkg::OP_LOAD_TOP);

  bip_ram #(
    .WIDTH (bip_pkg::SAMPLE_W),
    .DEPTH (bip_pkg::BLOCK_SIZE)
  ) u_left_ram (
    .clk   (clk),
    .we    (we_left),
    .waddr (head.entry.row),
    .wdata (head.entry.sample[bip_pkg::SAMPLE_W-1:0]),
    .re    (advance),
    .raddr (head.entry.row),
    .rdata (left_q)
  );

  bip_ram #(
    .WIDTH (bip_pkg::SAMPLE_W),
    .DEPTH (bip_pkg::BLOCK_SIZE)
  ) u_top_ram (
    .clk   (clk),
    .we    (we_top),
    .waddr (head.entry.col),
    .wdata (head.entry.sample[bip_pkg::SAMPLE_W-1:0]),
    .re    (advance),
    .raddr (head.entry.col),
    .rdata (top_q)
  );

  always_comb begin
    if (sample_bits == 5'd0) begin
      bits_eff = 5'd1;
    end else if (sample_bits > 5'd16) begin
      bits_eff = 5'd16;
    end else begin
      bits_eff = sample_bits;
    end
    grey   = bip_pkg::SAMPLE_W'(17'd1 << (bits_eff - 5'd1));
    maxval = (17'd1 << bits_eff) - 17'd1;
  end

  always_comb begin
    mode_eff = (pred_mode == bip_pkg::MODE_AUTO) ? {1'b0, top_avail, left_avail} : pred_mode;
    nb_sum   = {1'b0, left_q} + {1'b0, top_q};
    case (mode_eff)
      bip_pkg::MODE_LEFT: pred_next = left_avail ? left_q : grey;
      bip_pkg::MODE_TOP:  pred_next = top_avail ? top_q : grey;
      bip_pkg::MODE_AVG:  pred_next = (left_avail && top_avail) ? nb_sum[16:1] : grey;
      default:            pred_next = grey;
    endcase
  end

  always_comb begin
    max_s = $signed({1'b0, maxval});
    if (recon_mode) begin
      raw = $signed({b_sample[16], b_sample}) + $signed({2'b00, b_pred});
      if (raw > max_s) begin
        clipped = max_s;
      end else if (raw < 18'sd0) begin
        clipped = 18'sd0;
      end else begin
        clipped = raw;
      end
    end else begin
      raw = $signed({b_sample[16], b_sample}) - $signed({2'b00, b_pred});
      if (raw > max_s) begin
        clipped = max_s;
      end else if (raw < -max_s) begin
        clipped = -max_s;
      end else begin
        clipped = raw;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      b_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      a_valid   <= pop && (head.entry.kind == bip_pkg::OP_PIXEL);
      b_valid   <= a_valid;
      out_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      a_sample   <= head.entry.sample;
      b_sample   <= a_sample;
      b_pred     <= pred_next;
      out_pred   <= b_pred;
      out_result <= clipped[bip_pkg::VALUE_W-1:0];
    end
  end

  `BIP_ASSERT_NOW(a_no_pop_in_stall, pop, !(out_valid && !out_ready),
    "queue popped while output stalled")
  `BIP_ASSERT_NEXT(a_stage_holds, a_valid && !advance, a_valid,
    "pixel lost from read stage during stall")
  `BIP_ASSERT_NOW(a_recon_nonneg, out_valid && recon_mode, !out_result[16],
    "reconstructed pixel below zero")
  `BIP_ASSERT_NOW(a_resid_bound, out_valid && !recon_mode,
    ($signed({out_result[16], out_result}) <= max_s) &&
    ($signed({out_result[16], out_result}) >= -max_s), "residual outside clip range")

endmodule

// ===== hdl/block_intra_predictor_unit.sv =====
// Top level of the block intra predictor: front end, queue and back end.
// Depends on bip_pkg, bip_front and bip_back.
//
//   channel  direction  tdata fields (low bit up)                 tuser
//   s_*      in         row_index 8, col_index 8, sample_value 17  operation 2
//   m_*      out        prediction 16, result_value 17             -
//   cfg_*    in         register index 3, write data 5             -
//
// Sustained rate is one word per cycle on both sides while m_tready is high; a pixel
// goes via queue, store read and prediction registers to the clip output register.
// Reset clears the queue, pipeline valids and registers; the neighbor stores keep
// their contents and need no clearing. A stall on m_tready holds the back end, and
// the four-entry queue keeps the input side running until it fills.
module block_intra_predictor_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [bip_pkg::DATA_W-1:0]    s_tdata,   // row_index, col_index, sample_value
  input  logic [1:0]                    s_tuser,   // operation
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [bip_pkg::DATA_W-1:0]    m_tdata,   // prediction, result_value
  input  logic                          cfg_we,
  input  logic [bip_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bip_pkg::CFG_W-1:0]     cfg_data
);

  bip_pkg::head_t                     head;
  logic                               pop;
  logic [bip_pkg::SAMPLE_W-1:0]       out_pred;
  logic signed [bip_pkg::VALUE_W-1:0] out_result;

  bip_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .head     (head),
    .pop      (pop)
  );

  bip_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .head       (head),
    .pop        (pop),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_pred   (out_pred),
    .out_result (out_result)
  );

  assign m_tdata = {7'b0, out_result, out_pred};

endmodule
